### rtl/octave_jump_note_transposer_defines.svh
// ----------------------------------------------------------------------------
// Octave jump note transposer: assertion macros
// Shared concurrent assertion forms clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_JUMP_NOTE_TRANSPOSER_DEFINES_SVH
`define OCTAVE_JUMP_NOTE_TRANSPOSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OJNT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("octave_jump_note_transposer: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OJNT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("octave_jump_note_transposer: next-cycle check failed");

`endif

### rtl/ojnt_pkg.sv
// ----------------------------------------------------------------------------
// Octave jump note transposer package
// Shared types, message codes and reset constants.
// ----------------------------------------------------------------------------
package ojnt_pkg;

    localparam int NOTE_COUNT = 128;
    localparam int DEFAULT_MAX_SHIFT = 120;
    localparam int DEFAULT_FIFO_DEPTH = 4;

    localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
    localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
    localparam logic [1:0] KIND_WHEEL    = 2'd2;
    localparam logic [1:0] KIND_OTHER    = 2'd3;

    localparam logic [1:0] CFG_HIGH_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_LOW_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_STEP           = 2'd2;

    localparam logic [13:0] RESET_HIGH_THRESHOLD = 14'h3500;
    localparam logic [13:0] RESET_LOW_THRESHOLD  = 14'h0500;
    localparam logic [4:0]  RESET_STEP           = 5'd12;

    typedef enum logic [1:0] {
        OP_NOTE_OFF = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_FORWARD  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ZONE_MIDDLE = 2'd0,
        ZONE_HIGH   = 2'd1,
        ZONE_LOW    = 2'd2
    } zone_t;

    typedef struct packed {
        op_t               op;
        logic [3:0]        channel;
        logic [6:0]        note;
        logic [6:0]        velocity;
        logic signed [7:0] shift;
    } cmd_t;

endpackage

### rtl/octave_jump_note_transposer.sv
// ----------------------------------------------------------------------------
// Octave jump note transposer
// Path: an accepted note or forward message is written into the command queue,
// then into the back end's stage-one register and then into its output register.
// Throughput: one message per cycle while the command queue is not full.
// Reset: synchronous active-low aresetn clears the running shift, the wheel
// zone, the queue and all note-table valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module octave_jump_note_transposer import ojnt_pkg::*; #(
    parameter int MAX_SHIFT  = DEFAULT_MAX_SHIFT,
    parameter int FIFO_DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_note,
    input  logic [6:0]  s_velocity,
    input  logic [13:0] s_wheel_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [3:0]  m_out_channel,
    output logic [6:0]  m_out_note,
    output logic [6:0]  m_out_velocity
);

    logic q_full;
    logic q_push;
    cmd_t q_cmd;
    logic q_valid;
    cmd_t q_head;
    logic q_pop;

    ojnt_front #(
        .MAX_SHIFT(MAX_SHIFT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_channel    (s_channel),
        .s_note       (s_note),
        .s_velocity   (s_velocity),
        .s_wheel_value(s_wheel_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    ojnt_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop_valid(q_valid),
        .pop_cmd  (q_head),
        .pop      (q_pop)
    );

    ojnt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_valid),
        .cmd           (q_head),
        .cmd_ready     (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_out_channel (m_out_channel),
        .m_out_note    (m_out_note),
        .m_out_velocity(m_out_velocity)
    );

endmodule

### rtl/ojnt_front.sv
// ----------------------------------------------------------------------------
// Octave jump note transposer: front end
// Accepts messages, tracks the wheel zone and running shift, and queues
// note and forward commands for the back end.
// ----------------------------------------------------------------------------
`include "octave_jump_note_transposer_defines.svh"

module ojnt_front import ojnt_pkg::*; #(
    parameter int MAX_SHIFT = DEFAULT_MAX_SHIFT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [13:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [3:0]  s_channel,
    input  logic [6:0]  s_note,
    input  logic [6:0]  s_velocity,
    input  logic [13:0] s_wheel_value,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam logic signed [8:0] MAX_S = 9'(MAX_SHIFT);

    logic [13:0]       high_thr_reg;
    logic [13:0]       low_thr_reg;
    logic [4:0]        step_reg;
    zone_t             zone_reg;
    zone_t             zone_next;
    logic signed [7:0] shift_reg;
    logic signed [7:0] shift_next;
    logic signed [8:0] up_sum;
    logic signed [8:0] down_sum;
    logic              accept;
    logic signed [8:0] shift_ext;
    logic              wheel_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_thr_reg <= RESET_HIGH_THRESHOLD;
            low_thr_reg  <= RESET_LOW_THRESHOLD;
            step_reg     <= RESET_STEP;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_HIGH_THRESHOLD: high_thr_reg <= cfg_wdata;
                CFG_LOW_THRESHOLD:  low_thr_reg  <= cfg_wdata;
                CFG_STEP:           step_reg     <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg  <= ZONE_MIDDLE;
            shift_reg <= '0;
        end else begin
            zone_reg  <= zone_next;
            shift_reg <= shift_next;
        end
    end

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign up_sum   = {shift_reg[7], shift_reg} + $signed({4'b0000, step_reg});
    assign down_sum = {shift_reg[7], shift_reg} - $signed({4'b0000, step_reg});

    assign shift_ext    = {shift_reg[7], shift_reg};
    assign wheel_accept = accept && (s_kind == KIND_WHEEL);

    always_comb begin
        zone_next  = zone_reg;
        shift_next = shift_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        if (accept) begin
            unique case (s_kind)
                KIND_NOTE_OFF: begin
                    q_push         = 1'b1;
                    q_cmd.op       = OP_NOTE_OFF;
                    q_cmd.channel  = s_channel;
                    q_cmd.note     = s_note;
                    q_cmd.velocity = s_velocity;
                end
                KIND_NOTE_ON: begin
                    q_push         = 1'b1;
                    q_cmd.op       = OP_NOTE_ON;
                    q_cmd.channel  = s_channel;
                    q_cmd.note     = s_note;
                    q_cmd.velocity = s_velocity;
                    q_cmd.shift    = shift_reg;
                end
                KIND_WHEEL: begin
                    if (s_wheel_value > high_thr_reg) begin
                        zone_next = ZONE_HIGH;
                        if (zone_reg != ZONE_HIGH) begin
                            shift_next = (up_sum > MAX_S) ? MAX_S[7:0] : up_sum[7:0];
                        end
                    end else if (s_wheel_value < low_thr_reg) begin
                        zone_next = ZONE_LOW;
                        if (zone_reg != ZONE_LOW) begin
                            shift_next = (down_sum < -MAX_S) ? 8'(-MAX_S) : down_sum[7:0];
                        end
                    end else begin
                        zone_next = ZONE_MIDDLE;
                    end
                end
                KIND_OTHER: begin
                    q_push   = 1'b1;
                    q_cmd.op = OP_FORWARD;
                end
                default: ;
            endcase
        end
    end

    `OJNT_ASSERT_SAME(a_shift_bounded, 1'b1, (shift_ext <= MAX_S) && (shift_ext >= -MAX_S))
    `OJNT_ASSERT_NEXT(a_zone_only_on_wheel, !wheel_accept, $stable(zone_reg) && $stable(shift_reg))

endmodule

### rtl/ojnt_fifo.sv
// ----------------------------------------------------------------------------
// Octave jump note transposer: command queue
// Short first-word-fall-through queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "octave_jump_note_transposer_defines.svh"

module ojnt_fifo import ojnt_pkg::*; #(
    parameter int DEPTH = DEFAULT_FIFO_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic pop_valid,
    output cmd_t pop_cmd,
    input  logic pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;
    logic             grow;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign grow      = do_push && !do_pop;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (grow) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `OJNT_ASSERT_NEXT(a_count_tracks_push, grow, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

### rtl/ojnt_back.sv
// ----------------------------------------------------------------------------
// Octave jump note transposer: back end
// Reads or records the per-note shift, applies it, drops notes out of range
// and holds each result in an output register until its transaction.
// ----------------------------------------------------------------------------
`include "octave_jump_note_transposer_defines.svh"

module ojnt_back import ojnt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cmd_valid,
    input  cmd_t       cmd,
    output logic       cmd_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [3:0] m_out_channel,
    output logic [6:0] m_out_note,
    output logic [6:0] m_out_velocity
);

    logic signed [7:0]    table_mem [NOTE_COUNT];
    logic [NOTE_COUNT-1:0] tab_valid_reg;

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic signed [7:0] s1_tab_reg;
    logic              s1_hit_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [3:0]        out_channel_reg;
    logic [6:0]        out_note_reg;
    logic [6:0]        out_velocity_reg;

    logic              fire;
    logic signed [7:0] eff_shift;
    logic signed [8:0] shifted;
    logic              has_result;
    logic              out_free;
    logic              out_load;
    logic              s1_leave;
    logic              note_on_fire;
    logic              fwd_out;
    logic              fwd_zero;

    assign out_free  = !out_valid_reg || m_ready;
    assign eff_shift = (s1_cmd_reg.op == OP_NOTE_ON) ? s1_cmd_reg.shift :
                       (s1_hit_reg ? s1_tab_reg : 8'sd0);
    assign shifted   = $signed({2'b00, s1_cmd_reg.note}) + {eff_shift[7], eff_shift};
    assign has_result = (s1_cmd_reg.op == OP_FORWARD) || (shifted[8:7] == 2'b00);
    assign out_load  = s1_valid_reg && has_result && out_free;
    assign s1_leave  = s1_valid_reg && (!has_result || out_free);
    assign cmd_ready = !s1_valid_reg || s1_leave;
    assign fire      = cmd_valid && cmd_ready;
    assign note_on_fire = fire && (cmd.op == OP_NOTE_ON);

    always_ff @(posedge aclk) begin
        if (note_on_fire) begin
            table_mem[cmd.note] <= cmd.shift;
        end
        if (fire) begin
            s1_tab_reg <= table_mem[cmd.note];
            s1_hit_reg <= tab_valid_reg[cmd.note];
            s1_cmd_reg <= cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_valid_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end else begin
            if (note_on_fire) begin
                tab_valid_reg[cmd.note] <= 1'b1;
            end
            if (fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_leave) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg <= s1_cmd_reg.op;
            if (s1_cmd_reg.op == OP_FORWARD) begin
                out_channel_reg  <= '0;
                out_note_reg     <= '0;
                out_velocity_reg <= '0;
            end else begin
                out_channel_reg  <= s1_cmd_reg.channel;
                out_note_reg     <= shifted[6:0];
                out_velocity_reg <= s1_cmd_reg.velocity;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_out_kind     = out_kind_reg;
    assign m_out_channel  = out_channel_reg;
    assign m_out_note     = out_note_reg;
    assign m_out_velocity = out_velocity_reg;

    assign fwd_out  = out_valid_reg && (out_kind_reg == OP_FORWARD);
    assign fwd_zero = (out_channel_reg == '0) && (out_note_reg == '0) &&
                      (out_velocity_reg == '0);

    `OJNT_ASSERT_SAME(a_forward_fields_zero, fwd_out, fwd_zero)
    `OJNT_ASSERT_NEXT(a_note_on_recorded, note_on_fire, tab_valid_reg[$past(cmd.note)])

endmodule
